// ===== rtl/lhfe_pkg.sv =====
// Shared constants, widths and the fade duration table of the LED hold-and-fade engine.
`default_nettype none

package lhfe_pkg;

  // Number of LEDs with a stored start time
  localparam int unsigned LED_COUNT = 64;
  localparam int unsigned LedAw     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  // Field widths
  localparam int unsigned ModeW  = 1;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned ColW   = 8;
  localparam int unsigned SpeedW = 2;
  localparam int unsigned HoldW  = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 1;

  // Fade durations reach 1400 ms: 11 bits
  localparam int unsigned FadeW = 11;
  localparam int unsigned LimW  = HoldW + 1;
  // Blend numerator: colour times duration
  localparam int unsigned AccW  = ColW + FadeW;
  localparam int unsigned CntW  = $clog2(TimeW);
  localparam int unsigned Lanes = 3;

  // Item modes
  localparam logic [ModeW-1:0] MODE_TRIGGER = 1'b0;
  localparam logic [ModeW-1:0] MODE_QUERY   = 1'b1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_FADE_SPEED = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_TIME  = 1'b1;

  // Register reset values
  localparam logic [SpeedW-1:0] FADE_SPEED_RST = '0;
  localparam logic [HoldW-1:0]  HOLD_TIME_RST  = 16'd100;

  // Fade duration in ms for each speed setting
  function automatic logic [FadeW-1:0] fade_len(input logic [SpeedW-1:0] speed);
    logic [FadeW-1:0] len;
    case (speed)
      2'd0:    len = 11'd1400;
      2'd1:    len = 11'd1100;
      2'd2:    len = 11'd850;
      default: len = 11'd600;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lhfe_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none

module lhfe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  wire logic [Width-1:0]                          wdata_i,
  output logic      [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One read per cycle, plus a write to the same address when we_i is set
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/led_hold_and_fade_engine_core.sv =====
// Top level of the LED hold-and-fade engine: stamp store, bit-serial age unit, serial blend.
// Flow: a trigger, an out-of-range index or an inactive LED goes from idle to done, then to
//   the output register; an active LED goes through the stamp read, the serial age bits,
//   the decision, the multiply and divide steps (blend only), done and the output register.
// One item at a time: a new item is taken only once the last result has entered the output
//   register; the 32-bit serial age unit and the serial multiply/divide lanes set the pace.
// Reset clears all active flags and out_valid and sets the registers (speed 0, hold 100).
`default_nettype none

module led_hold_and_fade_engine_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_we_i,
  input  wire logic [lhfe_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [lhfe_pkg::CfgW-1:0]   cfg_data_i,
  // input channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [lhfe_pkg::ModeW-1:0]  mode_i,
  input  wire logic [lhfe_pkg::IdxW-1:0]   led_index_i,
  input  wire logic [lhfe_pkg::TimeW-1:0]  now_time_i,
  input  wire logic [lhfe_pkg::ColW-1:0]   base_red_i,
  input  wire logic [lhfe_pkg::ColW-1:0]   base_green_i,
  input  wire logic [lhfe_pkg::ColW-1:0]   base_blue_i,
  input  wire logic [lhfe_pkg::ColW-1:0]   opp_red_i,
  input  wire logic [lhfe_pkg::ColW-1:0]   opp_green_i,
  input  wire logic [lhfe_pkg::ColW-1:0]   opp_blue_i,
  // output channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             accepted_o,
  output logic                             running_o,
  output logic      [lhfe_pkg::ColW-1:0]   out_red_o,
  output logic      [lhfe_pkg::ColW-1:0]   out_green_o,
  output logic      [lhfe_pkg::ColW-1:0]   out_blue_o
);

  import lhfe_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RD   = 7'b0000010,
    ST_AGE  = 7'b0000100,
    ST_PREP = 7'b0001000,
    ST_MUL  = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [SpeedW-1:0] speed_q;
  logic [HoldW-1:0]  hold_q;

  // per-LED state
  logic [LED_COUNT-1:0] active_q;
  logic [TimeW-1:0]     ram_rdata;

  // item registers
  logic [CntW-1:0]             cnt_q;
  logic [TimeW-1:0]            now_sh_q;
  logic [TimeW-1:0]            stamp_sh_q;
  logic [HoldW-1:0]            hold_sh_q;
  logic [LimW-1:0]             lim_sh_q;
  logic [FadeW-1:0]            fade_q;
  logic [FadeW-1:0]            e_q;
  logic [FadeW-1:0]            dme_q;
  logic                        ba_q, bb_q, bc_q, nz_q;
  logic [Lanes-1:0][ColW-1:0]  base_q, opp_q;
  logic [Lanes-1:0][AccW-1:0]  acc_q;

  // pending result
  logic                        res_acc_q, res_run_q;
  logic [Lanes-1:0][ColW-1:0]  res_col_q;

  // output register
  logic                        out_valid_q;
  logic                        out_acc_q, out_run_q;
  logic [Lanes-1:0][ColW-1:0]  out_col_q;

  logic                        in_xfer, out_free, idx_ok;
  logic [LedAw-1:0]            addr;
  logic                        ram_we;

  assign in_xfer  = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign idx_ok   = ({1'b0, led_index_i} < (IdxW + 1)'(LED_COUNT));
  assign addr     = led_index_i[LedAw-1:0];
  assign ram_we   = in_xfer && (mode_i == MODE_TRIGGER) && idx_ok;

  // start time store
  lhfe_ram #(
    .Width (TimeW),
    .Depth (LED_COUNT)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (addr),
    .wdata_i (now_time_i),
    .rdata_o (ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= FADE_SPEED_RST;
      hold_q  <= HOLD_TIME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FADE_SPEED: speed_q <= cfg_data_i[SpeedW-1:0];
        CFG_HOLD_TIME:  hold_q  <= cfg_data_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  // active flags: set by a trigger, cleared only by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (ram_we) begin
      active_q[addr] <= 1'b1;
    end
  end

  // serial age unit: age = now - stamp, e = age - hold, age - (hold + fade)
  logic n_bit, s_bit, a_bit, b_bit, h_bit, l_bit;
  logic ba_d, bb_d, bc_d;

  assign n_bit = now_sh_q[0];
  assign s_bit = stamp_sh_q[0];
  assign h_bit = hold_sh_q[0];
  assign l_bit = lim_sh_q[0];
  assign a_bit = n_bit ^ s_bit ^ ba_q;
  assign ba_d  = (~n_bit & s_bit) | (~(n_bit ^ s_bit) & ba_q);
  assign b_bit = a_bit ^ h_bit ^ bb_q;
  assign bb_d  = (~a_bit & h_bit) | (~(a_bit ^ h_bit) & bb_q);
  assign bc_d  = (~a_bit & l_bit) | (~(a_bit ^ l_bit) & bc_q);

  // age at most hold when e borrowed or came out zero
  logic le_hold;
  assign le_hold = bb_q | ~nz_q;

  // multiply and divide steps, one per lane
  logic [Lanes-1:0][AccW-1:0] acc_mul, acc_div;

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      acc_mul[i] = {acc_q[i][AccW-2:0], 1'b0}
                 + (dme_q[FadeW-1] ? AccW'(opp_q[i]) : '0)
                 + (e_q[FadeW-1] ? AccW'(base_q[i]) : '0);
    end
  end

  always_comb begin
    logic [FadeW:0] t, r;
    logic           ge;
    for (int i = 0; i < Lanes; i++) begin
      t          = {acc_q[i][AccW-1:ColW], acc_q[i][ColW-1]};
      ge         = (t >= {1'b0, fade_q});
      r          = ge ? (t - {1'b0, fade_q}) : t;
      acc_div[i] = {r[FadeW-1:0], acc_q[i][ColW-2:0], ge};
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (mode_i == MODE_QUERY && idx_ok && active_q[addr]) begin
            state_d = ST_RD;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_RD:   state_d = ST_AGE;
      ST_AGE:  if (cnt_q == CntW'(TimeW - 1)) state_d = ST_PREP;
      ST_PREP: state_d = (!le_hold && bc_q) ? ST_MUL : ST_DONE;
      ST_MUL:  if (cnt_q == CntW'(FadeW - 1)) state_d = ST_DIV;
      ST_DIV:  if (cnt_q == CntW'(ColW - 1)) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          now_sh_q  <= now_time_i;
          hold_sh_q <= hold_q;
          lim_sh_q  <= LimW'(hold_q) + LimW'(fade_len(speed_q));
          fade_q    <= fade_len(speed_q);
          base_q    <= {base_blue_i, base_green_i, base_red_i};
          opp_q     <= {opp_blue_i, opp_green_i, opp_red_i};
          res_acc_q <= idx_ok;
          res_run_q <= 1'b0;
          if (mode_i == MODE_TRIGGER) begin
            res_col_q <= '0;
          end else begin
            res_col_q <= {base_blue_i, base_green_i, base_red_i};
          end
        end
      end
      ST_RD: begin
        stamp_sh_q <= ram_rdata;
        cnt_q      <= '0;
        ba_q       <= 1'b0;
        bb_q       <= 1'b0;
        bc_q       <= 1'b0;
        nz_q       <= 1'b0;
      end
      ST_AGE: begin
        now_sh_q   <= now_sh_q >> 1;
        stamp_sh_q <= stamp_sh_q >> 1;
        hold_sh_q  <= hold_sh_q >> 1;
        lim_sh_q   <= lim_sh_q >> 1;
        ba_q       <= ba_d;
        bb_q       <= bb_d;
        bc_q       <= bc_d;
        nz_q       <= nz_q | b_bit;
        // low bits of e, LSB first
        if (cnt_q < CntW'(FadeW)) begin
          e_q <= {b_bit, e_q[FadeW-1:1]};
        end
        cnt_q <= cnt_q + 1'b1;
      end
      ST_PREP: begin
        res_run_q <= bc_q;
        dme_q     <= fade_q - e_q;
        acc_q     <= '0;
        cnt_q     <= '0;
        if (le_hold) begin
          res_col_q <= opp_q;
        end
      end
      ST_MUL: begin
        acc_q <= acc_mul;
        dme_q <= dme_q << 1;
        e_q   <= e_q << 1;
        if (cnt_q == CntW'(FadeW - 1)) begin
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      ST_DIV: begin
        acc_q <= acc_div;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(ColW - 1)) begin
          for (int i = 0; i < Lanes; i++) begin
            res_col_q[i] <= acc_div[i][ColW-1:0];
          end
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_acc_q <= res_acc_q;
      out_run_q <= res_run_q;
      out_col_q <= res_col_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accepted_o  = out_acc_q;
  assign running_o   = out_run_q;
  assign out_red_o   = out_col_q[0];
  assign out_green_o = out_col_q[1];
  assign out_blue_o  = out_col_q[2];

  // checks
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q != ST_IDLE))
    else $error("engine idle after an input transfer");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the done state");

  a_flags_stick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (($past(active_q) & ~active_q) == '0))
    else $error("active flag cleared outside reset");

  a_running_needs_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_run_q || out_acc_q))
    else $error("running reported for a rejected index");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench of the LED hold-and-fade engine: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
  import lhfe_pkg::*;

  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 155;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned STUCK_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 80;

  // Fade length in ms per speed setting
  localparam int unsigned FADE_MS [4] = '{1400, 1100, 850, 600};

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [IdxW-1:0]  idx;
    logic [TimeW-1:0] now;
    logic [ColW-1:0]  base_red;
    logic [ColW-1:0]  base_green;
    logic [ColW-1:0]  base_blue;
    logic [ColW-1:0]  opp_red;
    logic [ColW-1:0]  opp_green;
    logic [ColW-1:0]  opp_blue;
  } led_item_t;

  typedef struct packed {
    logic            accepted;
    logic            running;
    logic [ColW-1:0] red;
    logic [ColW-1:0] green;
    logic [ColW-1:0] blue;
  } led_result_t;

  typedef struct {
    led_item_t   item;
    bit          fixed;
    led_result_t res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = CFG_FADE_SPEED;
  logic [CfgW-1:0]     cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  led_item_t           drv_item = '0;
  bit                  drv_fixed = 1'b0;
  led_result_t         drv_fixed_res = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                accepted;
  logic                running;
  logic [ColW-1:0]     out_red;
  logic [ColW-1:0]     out_green;
  logic [ColW-1:0]     out_blue;

  // Predictor state and settings
  logic [TimeW-1:0]  stamp_ms [LED_COUNT];
  bit                lit      [LED_COUNT];
  logic [SpeedW-1:0] speed_sel = FADE_SPEED_RST;
  logic [HoldW-1:0]  hold_ms   = HOLD_TIME_RST;

  // Stimulus-side record of trigger times
  logic [TimeW-1:0]  trig_ms   [LED_COUNT];
  bit                trig_seen [LED_COUNT];

  led_result_t expected_colours [$];
  stim_row_t   dir_table [$];
  int unsigned mismatches = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_seen;
  int unsigned hold_left;
  int unsigned stuck_cycles;

  led_hold_and_fade_engine_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .mode_i       (drv_item.mode),
    .led_index_i  (drv_item.idx),
    .now_time_i   (drv_item.now),
    .base_red_i   (drv_item.base_red),
    .base_green_i (drv_item.base_green),
    .base_blue_i  (drv_item.base_blue),
    .opp_red_i    (drv_item.opp_red),
    .opp_green_i  (drv_item.opp_green),
    .opp_blue_i   (drv_item.opp_blue),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .accepted_o   (accepted),
    .running_o    (running),
    .out_red_o    (out_red),
    .out_green_o  (out_green),
    .out_blue_o   (out_blue)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Linear blend of one channel, e ms into a fade of d ms
  function automatic logic [ColW-1:0] fade_mix(logic [ColW-1:0] from, logic [ColW-1:0] to,
                                               logic [31:0] e, logic [31:0] d);
    logic [31:0] num;
    num = 32'(from) * (d - e) + 32'(to) * e;
    return ColW'(num / d);
  endfunction

  // Result of one item; a trigger updates the stamp store
  function automatic led_result_t led_response(led_item_t it);
    led_result_t res;
    logic [31:0] age;
    logic [31:0] fade;
    logic [31:0] e;
    res = '0;
    res.accepted = (it.idx < LED_COUNT);
    if (it.mode == MODE_TRIGGER) begin
      if (res.accepted) begin
        stamp_ms[it.idx] = it.now;
        lit[it.idx] = 1'b1;
      end
      return res;
    end
    res.red   = it.base_red;
    res.green = it.base_green;
    res.blue  = it.base_blue;
    if (!res.accepted || !lit[it.idx]) return res;
    age  = it.now - stamp_ms[it.idx];
    fade = FADE_MS[speed_sel];
    res.running = (age < hold_ms + fade);
    if (age <= hold_ms) begin
      res.red   = it.opp_red;
      res.green = it.opp_green;
      res.blue  = it.opp_blue;
    end else begin
      e = age - hold_ms;
      if (e < fade) begin
        res.red   = fade_mix(it.opp_red, it.base_red, e, fade);
        res.green = fade_mix(it.opp_green, it.base_green, e, fade);
        res.blue  = fade_mix(it.opp_blue, it.base_blue, e, fade);
      end
    end
    return res;
  endfunction

  // Random item, mostly queries aimed at the hold, fade and settled windows of a lit LED
  function automatic led_item_t random_led_item();
    led_item_t   it;
    int unsigned pick;
    logic [31:0] fade;
    logic [31:0] age;
    it.mode = ($urandom_range(99) < 25) ? MODE_TRIGGER : MODE_QUERY;
    it.idx  = ($urandom_range(99) < 12) ? IdxW'($urandom_range(255))
                                        : IdxW'($urandom_range(LED_COUNT - 1));
    it.now        = $urandom();
    it.base_red   = ColW'($urandom());
    it.base_green = ColW'($urandom());
    it.base_blue  = ColW'($urandom());
    it.opp_red    = ColW'($urandom());
    it.opp_green  = ColW'($urandom());
    it.opp_blue   = ColW'($urandom());
    // an unlit LED is usually lit first so that queries find a running effect
    if (it.idx < LED_COUNT && it.mode == MODE_QUERY && !trig_seen[it.idx] &&
        $urandom_range(99) < 80)
      it.mode = MODE_TRIGGER;
    if (it.mode == MODE_TRIGGER) begin
      if (it.idx < LED_COUNT) begin
        trig_ms[it.idx]   = it.now;
        trig_seen[it.idx] = 1'b1;
      end
    end else if (it.idx < LED_COUNT && trig_seen[it.idx]) begin
      fade = FADE_MS[speed_sel];
      pick = $urandom_range(99);
      if (pick < 15) begin
        age = $urandom_range(hold_ms);
      end else if (pick < 25) begin
        case ($urandom_range(5))
          0:       age = 0;
          1:       age = hold_ms;
          2:       age = hold_ms + 1;
          3:       age = hold_ms + fade - 1;
          4:       age = hold_ms + fade;
          default: age = hold_ms + fade + 1;
        endcase
      end else if (pick < 70) begin
        age = hold_ms + $urandom_range(fade - 1, 1);
      end else if (pick < 85) begin
        age = hold_ms + fade + $urandom_range(5000);
      end else begin
        age = $urandom();
      end
      it.now = trig_ms[it.idx] + age;
    end
    return it;
  endfunction

  task automatic add_row(logic mode, logic [7:0] idx, logic [31:0] now, logic [23:0] base,
                         logic [23:0] opp, bit fixed, logic acc, logic run,
                         logic [23:0] rgb);
    stim_row_t row;
    row.item  = {mode, idx, now, base, opp};
    row.fixed = fixed;
    row.res   = {acc, run, rgb};
    dir_table.push_back(row);
  endtask

  // Offer one item after a random gap and hold it until the transfer
  task automatic offer_item(led_item_t it, bit fixed, led_result_t res);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    drv_item      <= it;
    drv_fixed     <= fixed;
    drv_fixed_res <= res;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Stop offering until every outstanding result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_colours.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_settings(logic [SpeedW-1:0] speed, logic [HoldW-1:0] hold);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_FADE_SPEED;
    cfg_data <= CfgW'(speed);
    @(posedge clk_i);
    cfg_idx  <= CFG_HOLD_TIME;
    cfg_data <= hold;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    speed_sel = speed;
    hold_ms   = hold;
  endtask

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
      mismatches++;
    end
  endtask

  // Predict on each input transfer, compare on each output transfer
  always @(posedge clk_i) begin
    led_result_t exp;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        exp = led_response(drv_item);
        if (drv_fixed) exp = drv_fixed_res;
        expected_colours.push_back(exp);
      end
      if (out_valid && !out_stall) begin
        if (expected_colours.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0h", $time,
                   {accepted, running, out_red, out_green, out_blue});
          mismatches++;
        end else begin
          exp = expected_colours.pop_front();
          check_field("accepted", 32'(exp.accepted), 32'(accepted));
          check_field("running", 32'(exp.running), 32'(running));
          check_field("out_red", 32'(exp.red), 32'(out_red));
          check_field("out_green", 32'(exp.green), 32'(out_green));
          check_field("out_blue", 32'(exp.blue), 32'(out_blue));
        end
      end
    end
  end

  // Result side: random stalls, or a long hold-off when asked for
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      hold_left  <= 0;
      holds_seen <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_seen != holds_asked) begin
      out_stall  <= 1'b1;
      hold_left  <= LONG_HOLD;
      holds_seen <= holds_seen + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stuck_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    led_item_t   it;
    led_result_t none;
    logic [SpeedW-1:0] speed;
    logic [HoldW-1:0]  hold;
    none = '0;
    for (int i = 0; i < LED_COUNT; i++) begin
      stamp_ms[i]  = '0;
      lit[i]       = 1'b0;
      trig_ms[i]   = '0;
      trig_seen[i] = 1'b0;
    end

    // Directed table, reset settings: hold 100 ms, fade 1400 ms
    add_row(MODE_QUERY,   8'd0,   32'h0000_0000, 24'h000000, 24'hFFFFFF, 1, 1, 0, 24'h000000);
    add_row(MODE_TRIGGER, 8'd255, 32'h1234_5678, 24'hFFFFFF, 24'hFFFFFF, 1, 0, 0, 24'h000000);
    add_row(MODE_QUERY,   8'd255, 32'hFFFF_FFFF, 24'hFFFFFF, 24'h000000, 1, 0, 0, 24'hFFFFFF);
    add_row(MODE_TRIGGER, 8'd64,  32'h0000_0000, 24'h000000, 24'h000000, 1, 0, 0, 24'h000000);
    add_row(MODE_QUERY,   8'd64,  32'h0000_0001, 24'h123456, 24'h654321, 1, 0, 0, 24'h123456);
    // LED 63 triggered just before the time wraps
    add_row(MODE_TRIGGER, 8'd63,  32'hFFFF_FFF0, 24'hFFFFFF, 24'hFFFFFF, 1, 1, 0, 24'h000000);
    add_row(MODE_QUERY,   8'd63,  32'h0000_0010, 24'h000000, 24'hFFFFFF, 1, 1, 1, 24'hFFFFFF);
    add_row(MODE_QUERY,   8'd63,  32'h0000_0054, 24'h000000, 24'hA5C3E1, 1, 1, 1, 24'hA5C3E1);
    // first, middle and last ms of the fade
    add_row(MODE_QUERY,   8'd63,  32'h0000_0055, 24'hFFFFFF, 24'h000000, 0, 0, 0, 24'h000000);
    add_row(MODE_QUERY,   8'd63,  32'h0000_0310, 24'h80FF00, 24'h00FF80, 0, 0, 0, 24'h000000);
    add_row(MODE_QUERY,   8'd63,  32'h0000_05CB, 24'hFFFFFF, 24'h000000, 0, 0, 0, 24'h000000);
    add_row(MODE_QUERY,   8'd63,  32'h0000_05CC, 24'h5A5A5A, 24'hFFFFFF, 1, 1, 0, 24'h5A5A5A);
    add_row(MODE_QUERY,   8'd63,  32'hFFFF_FFEF, 24'h010203, 24'hFFFFFF, 1, 1, 0, 24'h010203);
    add_row(MODE_TRIGGER, 8'd0,   32'h0000_0000, 24'h000000, 24'h000000, 1, 1, 0, 24'h000000);
    add_row(MODE_QUERY,   8'd0,   32'h0000_0000, 24'hF0F0F0, 24'h0F0F0F, 1, 1, 1, 24'h0F0F0F);
    add_row(MODE_QUERY,   8'd1,   32'h0000_0005, 24'h112233, 24'hFFFFFF, 1, 1, 0, 24'h112233);
    add_row(MODE_TRIGGER, 8'd63,  32'h7FFF_FFFF, 24'h000000, 24'h000000, 1, 1, 0, 24'h000000);
    add_row(MODE_QUERY,   8'd63,  32'h8000_0064, 24'hAA55AA, 24'h55AA55, 0, 0, 0, 24'h000000);
    add_row(MODE_TRIGGER, 8'd128, 32'hDEAD_BEEF, 24'h000000, 24'h000000, 1, 0, 0, 24'h000000);
    add_row(MODE_QUERY,   8'd200, 32'hDEAD_BEEF, 24'h3C3C3C, 24'hC3C3C3, 1, 0, 0, 24'h3C3C3C);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) begin
      offer_item(dir_table[i].item, dir_table[i].fixed, dir_table[i].res);
      if (dir_table[i].item.mode == MODE_TRIGGER && dir_table[i].item.idx < LED_COUNT) begin
        trig_ms[dir_table[i].item.idx]   = dir_table[i].item.now;
        trig_seen[dir_table[i].item.idx] = 1'b1;
      end
    end

    // Random phases, each with its own settings and idling
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0:       begin speed = 2'd0; hold = 16'd100; end
        1:       begin speed = 2'd3; hold = 16'd0; end
        2:       begin speed = 2'd1; hold = 16'hFFFF; end
        3:       begin speed = 2'd2; hold = HoldW'($urandom()); end
        4:       begin speed = 2'd3; hold = 16'hFFFF; end
        5:       begin speed = 2'd0; hold = 16'd0; end
        6:       begin speed = SpeedW'($urandom()); hold = HoldW'($urandom_range(300)); end
        default: begin speed = 2'd2; hold = 16'd1; end
      endcase
      write_settings(speed, hold);
      case (ph % 4)
        0:       begin gap_pct = 0;  stall_pct <= 0;  end
        1:       begin gap_pct = 49; stall_pct <= 0;  end
        2:       begin gap_pct = 0;  stall_pct <= 49; end
        default: begin gap_pct = 28; stall_pct <= 28; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long hold-off on the result side while items keep coming
        if (ph == 4 && n == 50) holds_asked <= holds_asked + 1;
        // sender pause until the block has emptied
        if (ph == 1 && n == 75) drain();
        it = random_led_item();
        offer_item(it, 1'b0, none);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_colours.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
